// ----- hdl/qhh_pkg.sv -----
package qhh_pkg;

  localparam int unsigned CORDIC_STEPS = 16;

  localparam int unsigned CntW  = $clog2(CORDIC_STEPS);
  localparam int unsigned TabW  = 5;
  localparam int unsigned AccW  = 34;
  localparam int unsigned XW    = 37;
  localparam int unsigned ZW    = 26;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulLast  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgYawNegate     = 3'd0,
    CfgOmegaDeadzone = 3'd1,
    CfgHoldGain      = 3'd2,
    CfgMaxCorrection = 3'd3,
    CfgTimeoutMs     = 3'd4
  } qhh_cfg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StPre,
    StIter,
    StUpdate,
    StGain,
    StDone
  } qhh_state_e;

  typedef struct packed {
    logic               quat_valid;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               zero_request;
    logic               hold_release;
    logic signed [15:0] omega_cmd;
    logic [31:0]        now_ms;
  } qhh_in_t;

  typedef struct packed {
    logic signed [15:0] heading_angle;
    logic signed [15:0] omega_out;
    logic               sensor_healthy;
    logic               hold_active;
  } qhh_out_t;

  typedef struct packed {
    logic            load;
    logic            mul;
    logic [1:0]      pair;
    logic            acc;
    logic [1:0]      acc_pair;
    logic            pre;
    logic            iter;
    logic [CntW-1:0] idx;
    logic            update;
    logic            gain;
    logic            emit;
  } qhh_cmd_t;

  typedef struct packed {
    logic quat_valid;
    logic out_free;
  } qhh_sts_t;

  // atan(2^-i), 2^23 = pi
  function automatic logic signed [ZW-1:0] atan_lut(input logic [TabW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(2097152);
      5'd1:    v = ZW'(1238021);
      5'd2:    v = ZW'(654136);
      5'd3:    v = ZW'(332050);
      5'd4:    v = ZW'(166669);
      5'd5:    v = ZW'(83416);
      5'd6:    v = ZW'(41718);
      5'd7:    v = ZW'(20860);
      5'd8:    v = ZW'(10430);
      5'd9:    v = ZW'(5215);
      5'd10:   v = ZW'(2608);
      5'd11:   v = ZW'(1304);
      5'd12:   v = ZW'(652);
      5'd13:   v = ZW'(326);
      5'd14:   v = ZW'(163);
      5'd15:   v = ZW'(81);
      5'd16:   v = ZW'(41);
      5'd17:   v = ZW'(20);
      5'd18:   v = ZW'(10);
      5'd19:   v = ZW'(5);
      5'd20:   v = ZW'(3);
      5'd21:   v = ZW'(1);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/quaternion_heading_hold_unit.sv -----
// Quaternion heading hold.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per control
// tick. A request is taken while the unit is idle; it stalls until the result
// of the previous request has been written to the output register.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// request, held in an output register, so the next request is taken while a
// finished result still waits for the receiver.
// Timing: a request carrying a quaternion goes from accept to out_valid_o through
// the quaternion products on the shared 16x16 multiplier, the pre-rotation, the
// CORDIC steps at one per cycle, then heading update, gain multiply and result
// write. Without a quaternion it goes straight to heading update, gain multiply
// and result write. The CORDIC iteration loop is the longest part of a request.
// A stalled receiver holds the result; the unit finishes the next request
// and waits in its last state until the output register frees.
// The user must make configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) only
// while the unit is idle; the block itself does not enforce it. Reset clears heading,
// offset, hold and sample time, and loads the default configuration.
module quaternion_heading_hold_unit import qhh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qhh_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qhh_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  qhh_cmd_t cmd;
  qhh_sts_t sts;

  qhh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qhh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- hdl/qhh_ctrl.sv -----
module qhh_ctrl import qhh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  qhh_sts_t sts_i,
  output qhh_cmd_t cmd_o
);

  qhh_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            iter_last;

  assign iter_last = (cnt_q == CntW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = sts_i.quat_valid ? StMul : StUpdate;
        end
      end
      StMul: begin
        if (cnt_q == CntW'(MulLast)) begin
          state_d = StPre;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StPre: begin
        state_d = StIter;
        cnt_d   = '0;
      end
      StIter: begin
        if (iter_last) begin
          state_d = StUpdate;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StUpdate: state_d = StGain;
      StGain:   state_d = StDone;
      StDone: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != StIdle);
    cmd_o          = '0;
    cmd_o.pair     = cnt_q[1:0];
    cmd_o.acc_pair = cnt_q[1:0] - 2'd1;
    cmd_o.idx      = cnt_q;
    unique case (state_q)
      StIdle:   cmd_o.load = in_valid_i;
      StMul: begin
        cmd_o.mul = (cnt_q != CntW'(MulLast));
        cmd_o.acc = (cnt_q != '0);
      end
      StPre:    cmd_o.pre = 1'b1;
      StIter:   cmd_o.iter = 1'b1;
      StUpdate: cmd_o.update = 1'b1;
      StGain:   cmd_o.gain = 1'b1;
      StDone:   cmd_o.emit = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result written while output register busy");

  a_iter_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIter && iter_last) |=> state_q == StUpdate)
    else $error("cordic did not hand over after last step");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!in_stall_o && state_q == StIdle))
    else $error("request loaded outside idle");

  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == StIdle)
    else $error("controller stuck after emit");

endmodule

// ----- hdl/qhh_datapath.sv -----
module qhh_datapath import qhh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qhh_in_t             in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output qhh_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  qhh_cmd_t            cmd_i,
  output qhh_sts_t            sts_o
);

  localparam logic signed [XW-1:0] DenOne  = XW'(64'h1000_0000);
  localparam logic signed [ZW-1:0] HalfPi  = ZW'(4194304);
  localparam logic signed [ZW-1:0] RoundHf = ZW'(128);

  // configuration
  logic        yaw_negate_q;
  logic [14:0] omega_deadzone_q;
  logic [15:0] hold_gain_q;
  logic [14:0] max_correction_q;
  logic [15:0] timeout_ms_q;

  // block state
  logic [15:0] heading_q, heading_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] target_q, target_d;
  logic        latched_q, latched_d;
  logic [31:0] last_ms_q, last_ms_d;
  logic        healthy_q, pass_q;
  logic        out_valid_q;
  qhh_out_t    out_q;

  // working registers
  qhh_in_t              item_q;
  logic signed [31:0]   prod_q;
  logic signed [AccW-1:0] acc_num_q, acc_den_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic                 zero_vec_q;
  logic signed [32:0]   gprod_q;

  logic signed [15:0]   op_a, op_b;
  logic signed [31:0]   prod_d;
  logic signed [XW-1:0] num, den, num_n, den_n;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;
  logic [15:0]          yaw_raw, yaw;
  logic [15:0]          h1;
  logic signed [16:0]   cmd17;
  logic [16:0]          mag;
  logic [31:0]          age;
  logic                 healthy_d, pass_d, latched_rel;
  logic signed [15:0]   err;
  logic signed [18:0]   corr, maxp, maxn, clamped;

  assign sts_o.quat_valid = in_data_i.quat_valid;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  // product source selection
  always_comb begin
    case (cmd_i.pair)
      2'd0:    begin op_a = item_q.quat_w; op_b = item_q.quat_z; end
      2'd1:    begin op_a = item_q.quat_x; op_b = item_q.quat_y; end
      2'd2:    begin op_a = item_q.quat_y; op_b = item_q.quat_y; end
      default: begin op_a = item_q.quat_z; op_b = item_q.quat_z; end
    endcase
    prod_d = op_a * op_b;
  end

  assign num   = XW'($signed({acc_num_q, 1'b0}));
  assign num_n = -num;
  assign den   = DenOne - XW'($signed({acc_den_q, 1'b0}));
  assign den_n = XW'($signed({acc_den_q, 1'b0})) - DenOne;

  assign xs = x_q >>> cmd_i.idx;
  assign ys = y_q >>> cmd_i.idx;

  // heading and hold update
  always_comb begin
    zr          = z_q + RoundHf;
    yaw_raw     = zero_vec_q ? 16'h0000 : zr[23:8];
    yaw         = yaw_negate_q ? (16'h0000 - yaw_raw) : yaw_raw;
    h1          = item_q.quat_valid ? (yaw - offset_q) : heading_q;
    last_ms_d   = item_q.quat_valid ? item_q.now_ms : last_ms_q;
    if (item_q.zero_request) begin
      offset_d  = offset_q + h1;
      heading_d = '0;
    end else begin
      offset_d  = offset_q;
      heading_d = h1;
    end
    latched_rel = latched_q && !item_q.hold_release;
    age         = item_q.now_ms - last_ms_d;
    healthy_d   = (age < {16'h0000, timeout_ms_q});
    cmd17       = 17'(item_q.omega_cmd);
    mag         = cmd17[16] ? 17'(-cmd17) : 17'(cmd17);
    pass_d      = !healthy_d || (mag > {2'b00, omega_deadzone_q});
    latched_d   = !pass_d;
    target_d    = (!pass_d && !latched_rel) ? heading_d : target_q;
  end

  assign err  = $signed(target_q - heading_q);
  assign corr = 19'(gprod_q >>> 14);
  assign maxp = $signed({4'b0000, max_correction_q});
  assign maxn = -maxp;

  always_comb begin
    if (corr > maxp) begin
      clamped = maxp;
    end else if (corr < maxn) begin
      clamped = maxn;
    end else begin
      clamped = corr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_negate_q     <= 1'b0;
      omega_deadzone_q <= 15'd410;
      hold_gain_q      <= 16'd4096;
      max_correction_q <= 15'd4096;
      timeout_ms_q     <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgYawNegate:     yaw_negate_q     <= cfg_data_i[0];
        CfgOmegaDeadzone: omega_deadzone_q <= cfg_data_i[14:0];
        CfgHoldGain:      hold_gain_q      <= cfg_data_i;
        CfgMaxCorrection: max_correction_q <= cfg_data_i[14:0];
        CfgTimeoutMs:     timeout_ms_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q   <= '0;
      offset_q    <= '0;
      target_q    <= '0;
      latched_q   <= 1'b0;
      last_ms_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        heading_q <= heading_d;
        offset_q  <= offset_d;
        target_q  <= target_d;
        latched_q <= latched_d;
        last_ms_q <= last_ms_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= in_data_i;
      acc_num_q <= '0;
      acc_den_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc) begin
      if (cmd_i.acc_pair[1]) begin
        acc_den_q <= acc_den_q + AccW'(prod_q);
      end else begin
        acc_num_q <= acc_num_q + AccW'(prod_q);
      end
    end
    if (cmd_i.pre) begin
      zero_vec_q <= (num == '0) && (den == '0);
      if (den < 0) begin
        if (num >= 0) begin
          x_q <= num;
          y_q <= den_n;
          z_q <= HalfPi;
        end else begin
          x_q <= num_n;
          y_q <= den;
          z_q <= -HalfPi;
        end
      end else begin
        x_q <= den;
        y_q <= num;
        z_q <= '0;
      end
    end
    if (cmd_i.iter) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_lut(TabW'(cmd_i.idx));
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_lut(TabW'(cmd_i.idx));
      end
    end
    if (cmd_i.update) begin
      healthy_q <= healthy_d;
      pass_q    <= pass_d;
    end
    if (cmd_i.gain) begin
      gprod_q <= $signed({1'b0, hold_gain_q}) * err;
    end
    if (cmd_i.emit) begin
      out_q.heading_angle  <= $signed(heading_q);
      out_q.omega_out      <= pass_q ? item_q.omega_cmd : clamped[15:0];
      out_q.sensor_healthy <= healthy_q;
      out_q.hold_active    <= latched_q;
    end
  end

endmodule

// ----- verif/quaternion_heading_hold_unit_tb.sv -----
module quaternion_heading_hold_unit_tb import qhh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1_000_000;
  localparam int SettleCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qhh_in_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qhh_out_t out_res;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CfgYawNegate;
  logic [CfgDataW-1:0] cfg_data = '0;

  always #10 clk_i = ~clk_i;

  quaternion_heading_hold_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // heading-hold configuration mirror
  logic neg_yaw = 1'b0;
  logic [14:0] dz_limit = 15'd410;
  logic [15:0] kp = 16'd4096;
  logic [14:0] corr_limit = 15'd4096;
  logic [15:0] stale_ms = 16'd200;

  // heading-hold state mirror
  logic [15:0] hdg = '0;
  logic [15:0] zoff = '0;
  logic [15:0] tgt = '0;
  logic latched = 1'b0;
  logic [31:0] last_ms = '0;

  qhh_in_t pending_ticks[$];
  qhh_out_t predicted_results[$];
  int n_queued = 0;
  int n_taken = 0;
  int n_results = 0;
  int mismatches = 0;
  logic [31:0] clock_ms = '0;

  function automatic longint atan_step(input int i);
    case (i)
      0: return 2097152;
      1: return 1238021;
      2: return 654136;
      3: return 332050;
      4: return 166669;
      5: return 83416;
      6: return 41718;
      7: return 20860;
      8: return 10430;
      9: return 5215;
      10: return 2608;
      11: return 1304;
      12: return 652;
      13: return 326;
      14: return 163;
      15: return 81;
      16: return 41;
      17: return 20;
      18: return 10;
      19: return 5;
      20: return 3;
      21: return 1;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // atan2(num, den), 2^23 = pi in the accumulator, rounded to a 16-bit angle
  function automatic logic [15:0] yaw_cordic(input longint num, input longint den);
    longint xv, yv, acc, t, xs, ys;
    if (num == 0 && den == 0) return 16'd0;
    xv = den;
    yv = num;
    acc = 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; acc = 4194304;
      end else begin
        t = xv; xv = -yv; yv = t; acc = -4194304;
      end
    end
    for (int i = 0; i < int'(CORDIC_STEPS) && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys; yv = yv - xs; acc = acc + atan_step(i);
      end else begin
        xv = xv - ys; yv = yv + xs; acc = acc - atan_step(i);
      end
    end
    t = (acc + 128) >>> 8;
    return t[15:0];
  endfunction

  function automatic qhh_out_t heading_hold_step(input qhh_in_t t);
    qhh_out_t r;
    longint w, x, y, zq, num, den, cmd, mag, err, corr;
    logic [15:0] yaw, diff, omega;
    logic [31:0] age;
    logic healthy;
    cmd = longint'($signed(t.omega_cmd));
    mag = (cmd < 0) ? -cmd : cmd;
    omega = t.omega_cmd;
    if (t.quat_valid) begin
      w = longint'($signed(t.quat_w));
      x = longint'($signed(t.quat_x));
      y = longint'($signed(t.quat_y));
      zq = longint'($signed(t.quat_z));
      num = 2 * (w * zq + x * y);
      den = (longint'(1) << 28) - 2 * (y * y + zq * zq);
      yaw = yaw_cordic(num, den);
      if (neg_yaw) yaw = 16'd0 - yaw;
      hdg = yaw - zoff;
      last_ms = t.now_ms;
    end
    if (t.zero_request) begin
      zoff = zoff + hdg;
      hdg = '0;
    end
    if (t.hold_release) latched = 1'b0;
    age = t.now_ms - last_ms;
    healthy = (age < {16'd0, stale_ms});
    if (!healthy || mag > longint'(dz_limit)) begin
      latched = 1'b0;
    end else begin
      if (!latched) begin
        tgt = hdg;
        latched = 1'b1;
      end
      diff = tgt - hdg;
      err = longint'($signed(diff));
      corr = (longint'(kp) * err) >>> 14;
      if (corr > longint'(corr_limit)) corr = longint'(corr_limit);
      if (corr < -longint'(corr_limit)) corr = -longint'(corr_limit);
      omega = corr[15:0];
    end
    r.heading_angle = hdg;
    r.omega_out = omega;
    r.sensor_healthy = healthy;
    r.hold_active = latched;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s at result %0d: got %0d, expected %0d", what, n_results, got, want);
  endtask

  task automatic check_result(input qhh_out_t got);
    qhh_out_t want;
    n_results++;
    if (predicted_results.size() == 0) begin
      flag_mismatch("result without request", 0, 0);
      return;
    end
    want = predicted_results.pop_front();
    if (got.heading_angle !== want.heading_angle)
      flag_mismatch("heading_angle", longint'($signed(got.heading_angle)),
                    longint'($signed(want.heading_angle)));
    if (got.omega_out !== want.omega_out)
      flag_mismatch("omega_out", longint'($signed(got.omega_out)),
                    longint'($signed(want.omega_out)));
    if (got.sensor_healthy !== want.sensor_healthy)
      flag_mismatch("sensor_healthy", longint'(got.sensor_healthy),
                    longint'(want.sensor_healthy));
    if (got.hold_active !== want.hold_active)
      flag_mismatch("hold_active", longint'(got.hold_active), longint'(want.hold_active));
  endtask

  // request driver
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(heading_hold_step(in_req));
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_valid <= 1'b1;
          in_req <= pending_ticks.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int holdoff_left = 0;
  int stall_epoch = 0;
  logic [15:0] stall_bits = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_res);
        if (n_results % 500 == 250) holdoff_left = 400;
      end
      if (stall_epoch == 0) begin
        stall_epoch = 200;
        case ($urandom_range(0, 3))
          0: stall_bits = '0;
          1: stall_bits = 16'($urandom);
          2: stall_bits = 16'($urandom | $urandom);
          default: stall_bits = 16'($urandom & $urandom);
        endcase
      end
      stall_epoch--;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[15:1]};
      end
    end
  end

  task automatic set_reg(input qhh_cfg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CfgYawNegate: neg_yaw = val[0];
      CfgOmegaDeadzone: dz_limit = val[14:0];
      CfgHoldGain: kp = val;
      CfgMaxCorrection: corr_limit = val[14:0];
      CfgTimeoutMs: stale_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [15:0] ng, input logic [15:0] dz, input logic [15:0] g,
                         input logic [15:0] mc, input logic [15:0] to);
    set_reg(CfgYawNegate, ng);
    set_reg(CfgOmegaDeadzone, dz);
    set_reg(CfgHoldGain, g);
    set_reg(CfgMaxCorrection, mc);
    set_reg(CfgTimeoutMs, to);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(input logic qv, input int w, input int x, input int y, input int z,
                           input logic zr, input logic hr, input int cmd,
                           input logic [31:0] now);
    qhh_in_t t;
    t.quat_valid = qv;
    t.quat_w = 16'(w);
    t.quat_x = 16'(x);
    t.quat_y = 16'(y);
    t.quat_z = 16'(z);
    t.zero_request = zr;
    t.hold_release = hr;
    t.omega_cmd = 16'(cmd);
    t.now_ms = now;
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  function automatic int quat_part();
    case ($urandom_range(0, 5))
      0: return int'($signed(16'($urandom)));
      1: return int'($urandom_range(0, 128)) - 64;
      2: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return 16384;
          3: return -16384;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  task automatic push_random_tick();
    int cmd;
    logic qv;
    qv = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0: cmd = int'($urandom);
      1: begin
        cmd = int'(dz_limit) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) cmd = -cmd;
      end
      default: cmd = int'($urandom_range(0, 800)) - 400;
    endcase
    case ($urandom_range(0, 39))
      0: clock_ms = $urandom;
      1: clock_ms += $urandom_range(150, 70000);
      default: clock_ms += $urandom_range(0, 25);
    endcase
    push_tick(qv, quat_part(), quat_part(), quat_part(), quat_part(),
              $urandom_range(0, 29) == 0, $urandom_range(0, 19) == 0, cmd, clock_ms);
  endtask

  task automatic drain();
    while (!(n_taken == n_queued && predicted_results.size() == 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int count;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_tick(0, 0, 0, 0, 0, 0, 0, 0, 5);
    push_tick(1, 16384, 0, 0, 0, 0, 0, 0, 10);
    push_tick(1, 11585, 0, 0, 11585, 0, 0, 0, 20);
    push_tick(1, 0, 0, 0, 16384, 0, 0, 0, 30);
    push_tick(1, 0, 0, 8192, 8192, 0, 0, 0, 40);
    push_tick(1, -32768, -32768, -32768, -32768, 0, 0, 410, 50);
    push_tick(1, 32767, 32767, 32767, 32767, 0, 0, 411, 60);
    push_tick(1, 32767, -32768, 32767, -32768, 0, 0, -32768, 70);
    push_tick(1, 11585, 0, 0, -11585, 1, 0, 0, 80);
    push_tick(1, 0, 16384, 0, 0, 0, 1, -410, 90);
    push_tick(1, -16384, 0, 0, 16384, 0, 0, 32767, 100);
    push_tick(0, 0, 0, 0, 0, 1, 0, 0, 299);
    push_tick(0, 0, 0, 0, 0, 0, 0, 0, 300);
    push_tick(1, 12000, -5000, 7000, -9000, 0, 0, 5, 32'hFFFF_FFF0);
    push_tick(0, 0, 0, 0, 0, 0, 0, 5, 32'h0000_0010);
    push_tick(1, -1, 1, -1, 1, 0, 0, -1, 32'h8000_0000);
    push_tick(1, 16384, 0, 0, 0, 0, 1, 0, 32'h8000_0001);
    push_tick(1, 0, 0, 16384, 0, 0, 0, 0, 32'h8000_0002);
    push_tick(1, 8192, 0, 0, -16384, 0, 0, 0, 32'h8000_0003);
    push_tick(1, -32768, 0, 0, 0, 1, 1, -32767, 32'h8000_0004);
    clock_ms = 32'h8000_0004;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_all(16'd1, 16'd32767, 16'd65535, 16'd32767, 16'd65535);
          count = 400;
        end
        1: begin
          set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
          count = 250;
        end
        2: begin
          set_all(16'($urandom_range(0, 1)), 16'd410, 16'd4096, 16'd4096, 16'd0);
          count = 60;
        end
        default: begin
          set_all(16'($urandom_range(0, 1)), 16'($urandom_range(50, 3000)), 16'($urandom),
                  16'($urandom_range(0, 32767)), 16'($urandom_range(30, 3000)));
          count = 350;
        end
      endcase
      repeat (count) push_random_tick();
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule
